@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// Shared definitions for the sorted priority queue: operation and status
// codes and the command bundle from the controller to the datapath.
// No dependencies.
package spq_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] stat_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_POP    = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;
    localparam op_t OP_CLEAR  = 2'd3;

    localparam stat_t STAT_OK   = 2'd0;
    localparam stat_t STAT_FULL = 2'd1;
    localparam stat_t STAT_DUP  = 2'd2;
    localparam stat_t STAT_MISS = 2'd3;

    // capture: latch the transaction and register the cell compares.
    // apply:   update the cells and load the result register.
    typedef struct packed {
        logic capture;
        logic apply;
    } spq_cmd_t;

endpackage

@@ rtl/spq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the sorted priority queue: two-state sequencer and the
// output valid flag. Depends on spq_pkg.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output spq_cmd_t cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        cmd.capture = in_valid && in_ready;
        cmd.apply   = (state_reg == ST_APPLY) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (cmd.apply)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.apply)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A captured transaction always moves on to the update step.
    a_capture_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_APPLY))
        else $error("capture did not lead to the update step");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.apply)
        else $error("result register overwritten while stalled");

    // Every update leaves a result on offer.
    a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> out_valid_reg)
        else $error("update produced no result");

endmodule

@@ rtl/spq_datapath.sv @@
`timescale 1ns / 1ps
// Datapath for the sorted priority queue: a row of sorted cells with
// per-cell compares, the entry count and the result register. Depends on spq_pkg.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  spq_cmd_t    cmd,
    input  op_t         op,
    input  logic [31:0] node_index,
    input  logic [31:0] node_key,
    input  logic [31:0] node_cost,
    output stat_t       status,
    output logic        found,
    output logic [31:0] out_index,
    output logic [31:0] out_key,
    output logic [31:0] out_cost
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [31:0] cell_key_reg   [DEPTH];
    logic [31:0] cell_index_reg [DEPTH];
    logic [31:0] cell_cost_reg  [DEPTH];
    logic [31:0] cell_key_next   [DEPTH];
    logic [31:0] cell_index_next [DEPTH];
    logic [31:0] cell_cost_next  [DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [DEPTH-1:0] le_reg, le_next;
    logic [DEPTH-1:0] match_reg, match_next;

    op_t         op_reg;
    logic [31:0] new_index_reg, new_key_reg, new_cost_reg;

    stat_t       status_reg, status_next;
    logic        found_reg, found_next;
    logic [31:0] out_index_reg, out_index_next;
    logic [31:0] out_key_reg, out_key_next;
    logic [31:0] out_cost_reg, out_cost_next;

    logic        dup, full, empty;
    logic [31:0] hit_index, hit_key, hit_cost;

    // Each cell compares its own entry against the incoming transaction.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            le_next[i]    = (count_reg > CNT_W'(i)) && (cell_key_reg[i] <= node_key);
            match_next[i] = (count_reg > CNT_W'(i)) && (cell_index_reg[i] == node_index);
        end
    end

    // Indices are unique in the queue, so at most one match bit is set and
    // the matching entry is picked out with an AND-OR select.
    always_comb
    begin
        hit_index = '0;
        hit_key   = '0;
        hit_cost  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_index = hit_index | (cell_index_reg[i] & {32{match_reg[i]}});
            hit_key   = hit_key   | (cell_key_reg[i]   & {32{match_reg[i]}});
            hit_cost  = hit_cost  | (cell_cost_reg[i]  & {32{match_reg[i]}});
        end
    end

    always_comb
    begin
        dup   = |match_reg;
        full  = (count_reg == CNT_W'(DEPTH));
        empty = (count_reg == '0);

        cell_key_next   = cell_key_reg;
        cell_index_next = cell_index_reg;
        cell_cost_next  = cell_cost_reg;
        count_next      = count_reg;

        status_next    = STAT_OK;
        found_next     = 1'b0;
        out_index_next = '0;
        out_key_next   = '0;
        out_cost_next  = '0;

        unique case (op_reg)
            OP_INSERT:
            begin
                if (dup)
                    status_next = STAT_DUP;
                else if (full)
                    status_next = STAT_FULL;
                else
                begin
                    // Cells with a key at or below the new one hold; the first
                    // cell past them takes the new entry, the rest shift up.
                    if (!le_reg[0])
                    begin
                        cell_key_next[0]   = new_key_reg;
                        cell_index_next[0] = new_index_reg;
                        cell_cost_next[0]  = new_cost_reg;
                    end
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        if (!le_reg[i])
                        begin
                            if (le_reg[i-1])
                            begin
                                cell_key_next[i]   = new_key_reg;
                                cell_index_next[i] = new_index_reg;
                                cell_cost_next[i]  = new_cost_reg;
                            end
                            else
                            begin
                                cell_key_next[i]   = cell_key_reg[i-1];
                                cell_index_next[i] = cell_index_reg[i-1];
                                cell_cost_next[i]  = cell_cost_reg[i-1];
                            end
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (empty)
                    status_next = STAT_MISS;
                else
                begin
                    found_next     = 1'b1;
                    out_index_next = cell_index_reg[0];
                    out_key_next   = cell_key_reg[0];
                    out_cost_next  = cell_cost_reg[0];
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        cell_key_next[i]   = cell_key_reg[i+1];
                        cell_index_next[i] = cell_index_reg[i+1];
                        cell_cost_next[i]  = cell_cost_reg[i+1];
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_LOOKUP:
            begin
                if (dup)
                begin
                    found_next     = 1'b1;
                    out_index_next = hit_index;
                    out_key_next   = hit_key;
                    out_cost_next  = hit_cost;
                end
                else
                    status_next = STAT_MISS;
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            le_reg    <= '0;
            match_reg <= '0;
            op_reg    <= OP_CLEAR;
        end
        else
        begin
            if (cmd.capture)
            begin
                le_reg    <= le_next;
                match_reg <= match_next;
                op_reg    <= op;
            end
            if (cmd.apply)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            new_index_reg <= node_index;
            new_key_reg   <= node_key;
            new_cost_reg  <= node_cost;
        end
        if (cmd.apply)
        begin
            cell_key_reg   <= cell_key_next;
            cell_index_reg <= cell_index_next;
            cell_cost_reg  <= cell_cost_next;
            status_reg     <= status_next;
            found_reg      <= found_next;
            out_index_reg  <= out_index_next;
            out_key_reg    <= out_key_next;
            out_cost_reg   <= out_cost_next;
        end
    end

    assign status    = status_reg;
    assign found     = found_reg;
    assign out_index = out_index_reg;
    assign out_key   = out_key_reg;
    assign out_cost  = out_cost_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond queue depth");

    // Duplicate indices are refused, so a lookup can hit at most one cell.
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_reg))
        else $error("node index present in more than one cell");

    // The cells stay sorted, so the key compares form a thermometer from cell 0.
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        ((le_reg >> 1) & ~le_reg) == '0)
        else $error("cell keys out of order");

endmodule

@@ rtl/sorted_priority_queue_top.sv @@
`timescale 1ns / 1ps
// Sorted priority queue for a shortest-path open set. Top level joining the
// controller and the cell datapath. Depends on spq_pkg, spq_ctrl, spq_datapath.
//
// Usage: an input transaction (op, node_index, node_key, node_cost) is taken
// when in_valid and in_ready are both high. op selects insert, pop of the
// smallest key, lookup by node index, or clear. Each input transaction yields
// exactly one result transaction (status, found, out_index, out_key, out_cost),
// taken when out_valid and out_ready are both high.
//
// Timing: the accept edge registers the compares of every cell against the
// new transaction; the update step, which can stall (see Stalls), updates the
// sorted cells and loads the result register, and out_valid rises with that load.
// The two-step controller takes no new transaction until the last is applied;
// each cell has its own key and index comparators, so depth adds no steps.
//
// Stalls: a new transaction is accepted while the previous result still waits
// in the output register; if out_ready stays low, the update step holds until
// that result is taken, and in_ready stays low meanwhile.
//
// Reset: rst_n clears the entry count, so the queue comes up empty at once.
// Cell contents are not cleared; no clearing pass is needed.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  op_t         op,
    input  logic [31:0] node_index,
    input  logic [31:0] node_key,
    input  logic [31:0] node_cost,
    output logic        out_valid,
    input  logic        out_ready,
    output stat_t       status,
    output logic        found,
    output logic [31:0] out_index,
    output logic [31:0] out_key,
    output logic [31:0] out_cost
);

    // Commands from the sequencer to the cells: capture then apply.
    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (op),
        .node_index (node_index),
        .node_key   (node_key),
        .node_cost  (node_cost),
        .status     (status),
        .found      (found),
        .out_index  (out_index),
        .out_key    (out_key),
        .out_cost   (out_cost)
    );

endmodule
